// ===== design/prf_pkg.sv =====
// Shared types and constants of the pilot phase regression frequency core.
// Holds field widths, reset values, state machine encodings and control structs.
// No dependencies.
package prf_pkg;

    // Field and datapath widths
    localparam int PH_W      = 16;
    localparam int FREQ_W    = 32;
    localparam int OFF_W     = 32;
    localparam int U_W       = OFF_W + 1;
    localparam int SUM_W     = 48;
    localparam int LEN_REG_W = 7;
    localparam int FRAC_W    = 16;
    localparam int QUO_W     = FREQ_W + 1;

    // Defaults for the top level parameters
    localparam int FFT_LEN_DEF = 64;
    localparam int MAX_LEN_DEF = 64;

    // Register reset value
    localparam logic [LEN_REG_W-1:0] LEN_RESET = 7'd16;

    // One full turn and half a turn in Q15 phase units
    localparam logic signed [OFF_W-1:0] TURN      = 32'sd65536;
    localparam logic signed [PH_W:0]    HALF_TURN = 17'sd32768;

    // Saturation limits of the frequency word
    localparam logic [FREQ_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [FREQ_W-1:0] SAT_NEG = 32'h8000_0000;

    // Main sequencer states
    typedef enum logic [3:0] {
        T_IDLE,
        T_UNW0,
        T_MAC0,
        T_UNW1,
        T_MAC1,
        T_GO0,
        T_WAIT0,
        T_GO1,
        T_WAIT1,
        T_PUSH
    } t_top_state;

    // Slope unit states
    typedef enum logic [3:0] {
        SL_IDLE,
        SL_D1,
        SL_D2,
        SL_D3,
        SL_NUM,
        SL_NUMR,
        SL_ABS,
        SL_LOAD,
        SL_DIV,
        SL_DONE
    } t_slp_state;

    // Control from the sequencer to the accumulator
    typedef struct packed {
        logic unw;    // unwrap the selected pilot
        logic mac;    // add the unwrapped phase to the sums
        logic sel;    // pilot select
        logic seed;   // first word after reset
        logic clear;  // clear both pilots' sums
    } t_acc_ctl;

endpackage

// ===== design/prf_in_if.sv =====
// Input channel of the pilot phase regression core: one phase pair per word.
// Depends on prf_pkg for field widths.
interface prf_in_if;
    logic                              valid;
    logic                              ready;
    logic signed [prf_pkg::PH_W-1:0]   phase_pilot0;
    logic signed [prf_pkg::PH_W-1:0]   phase_pilot1;

    modport source (output valid, output phase_pilot0, output phase_pilot1, input ready);
    modport sink   (input valid, input phase_pilot0, input phase_pilot1, output ready);
endinterface

// ===== design/prf_out_if.sv =====
// Output channel of the pilot phase regression core: one frequency pair per word.
// Depends on prf_pkg for field widths.
interface prf_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [prf_pkg::FREQ_W-1:0] freq_pilot0;
    logic signed [prf_pkg::FREQ_W-1:0] freq_pilot1;

    modport source (output valid, output freq_pilot0, output freq_pilot1, input ready);
    modport sink   (input valid, input freq_pilot0, input freq_pilot1, output ready);
endinterface

// ===== design/prf_accum.sv =====
// Phase unwrap and regression sums for both pilots, one pilot per step.
// Depends on prf_pkg (widths, t_acc_ctl).
module prf_accum #(
    parameter int MAX_LEN = prf_pkg::MAX_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  prf_pkg::t_acc_ctl                  i_ctl,
    input  logic [$clog2(MAX_LEN+1)-1:0]       i_weight,
    input  logic signed [prf_pkg::PH_W-1:0]    i_phase0,
    input  logic signed [prf_pkg::PH_W-1:0]    i_phase1,
    output logic signed [prf_pkg::SUM_W-1:0]   o_sum,
    output logic signed [prf_pkg::SUM_W-1:0]   o_wsum
);

    localparam int LEN_W = $clog2(MAX_LEN+1);
    localparam int MUL_W = prf_pkg::U_W + LEN_W + 1;

    logic signed [prf_pkg::PH_W-1:0]  r_prev [2];
    logic signed [prf_pkg::OFF_W-1:0] r_off  [2];
    logic signed [prf_pkg::SUM_W-1:0] r_sum  [2];
    logic signed [prf_pkg::SUM_W-1:0] r_wsum [2];
    logic signed [prf_pkg::U_W-1:0]   r_u;

    logic signed [prf_pkg::PH_W-1:0]  raw;
    logic signed [prf_pkg::PH_W-1:0]  prev;
    logic signed [prf_pkg::OFF_W-1:0] off;
    logic signed [prf_pkg::PH_W:0]    step;
    logic signed [prf_pkg::OFF_W-1:0] n_off;
    logic signed [prf_pkg::U_W-1:0]   n_u;
    logic signed [MUL_W-1:0]          wprod;

    // Unwrap the selected pilot against its previous raw phase
    always_comb begin
        raw  = i_ctl.sel ? i_phase1 : i_phase0;
        prev = i_ctl.seed ? raw : r_prev[i_ctl.sel];
        off  = i_ctl.seed ? '0 : r_off[i_ctl.sel];
        step = {raw[prf_pkg::PH_W-1], raw} - {prev[prf_pkg::PH_W-1], prev};
        if (step > prf_pkg::HALF_TURN) begin
            n_off = off - prf_pkg::TURN;
        end else if (step < -prf_pkg::HALF_TURN) begin
            n_off = off + prf_pkg::TURN;
        end else begin
            n_off = off;
        end
        n_u = prf_pkg::U_W'(n_off) + prf_pkg::U_W'(raw);
    end

    // Weight the registered unwrapped phase by its index in the block
    assign wprod = r_u * $signed({1'b0, i_weight});

    // Hold unwrap history and sums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < 2; p++) begin
                r_prev[p] <= '0;
                r_off[p]  <= '0;
                r_sum[p]  <= '0;
                r_wsum[p] <= '0;
            end
            r_u <= '0;
        end else begin
            if (i_ctl.unw) begin
                r_prev[i_ctl.sel] <= raw;
                r_off[i_ctl.sel]  <= n_off;
                r_u               <= n_u;
            end
            if (i_ctl.mac) begin
                r_sum[i_ctl.sel]  <= r_sum[i_ctl.sel] + prf_pkg::SUM_W'(r_u);
                r_wsum[i_ctl.sel] <= r_wsum[i_ctl.sel] + prf_pkg::SUM_W'(wprod);
            end
            if (i_ctl.clear) begin
                for (int p = 0; p < 2; p++) begin
                    r_sum[p]  <= '0;
                    r_wsum[p] <= '0;
                end
            end
        end
    end

    assign o_sum  = r_sum[i_ctl.sel];
    assign o_wsum = r_wsum[i_ctl.sel];

endmodule

// ===== design/prf_slope.sv =====
// Least-squares slope of one pilot: shared multiplier, then a 33-step divider.
// Depends on prf_pkg (widths, t_slp_state, saturation limits).
module prf_slope #(
    parameter int FFT_LEN = prf_pkg::FFT_LEN_DEF,
    parameter int MAX_LEN = prf_pkg::MAX_LEN_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  logic [$clog2(MAX_LEN+1)-1:0]       i_len,
    input  logic signed [prf_pkg::SUM_W-1:0]   i_sum,
    input  logic signed [prf_pkg::SUM_W-1:0]   i_wsum,
    output logic                               o_done,
    output logic signed [prf_pkg::FREQ_W-1:0]  o_freq
);

    localparam int LP_W   = $clog2(MAX_LEN+2);
    localparam int C6_W   = $clog2(6*(MAX_LEN+1)+1);
    localparam int FFT_W  = $clog2(FFT_LEN+1);
    localparam int B_W    = (C6_W > FFT_W) ? C6_W : FFT_W;
    localparam int A_W    = prf_pkg::SUM_W + 1;
    localparam int P_W    = A_W + B_W;
    localparam int DEN_W  = 3*LP_W + FFT_W;
    localparam int NUM_W  = prf_pkg::SUM_W + B_W + 2;
    localparam int DIVA_W = NUM_W + prf_pkg::FRAC_W + 1;
    localparam int DIVB_W = DEN_W + prf_pkg::QUO_W - 1;
    localparam int DIV_W  = (DIVA_W > DIVB_W) ? DIVA_W : DIVB_W;
    localparam int STEP_W = $clog2(prf_pkg::QUO_W);

    prf_pkg::t_slp_state r_state, n_state;

    logic signed [P_W-1:0]         r_prod;
    logic [DEN_W-1:0]              r_den;
    logic signed [NUM_W-1:0]       r_w12;
    logic signed [NUM_W-1:0]       r_num;
    logic                          r_neg;
    logic [NUM_W-1:0]              r_mag;
    logic [DIV_W-1:0]              r_rem;
    logic [DIV_W-1:0]              r_dsh;
    logic [prf_pkg::QUO_W-1:0]     r_quo;
    logic [STEP_W-1:0]             r_step;

    logic signed [A_W-1:0]         mul_a;
    logic [B_W-1:0]                mul_b;
    logic signed [A_W+B_W:0]       mul_p;
    logic [B_W-1:0]                len_p1;
    logic signed [NUM_W-1:0]       wsum_x;
    logic                          ge;
    logic                          last_step;
    logic [prf_pkg::FREQ_W-1:0]    quo_t;
    logic                          big;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prf_pkg::SL_IDLE: if (i_start) n_state = prf_pkg::SL_D1;
            prf_pkg::SL_D1:   n_state = prf_pkg::SL_D2;
            prf_pkg::SL_D2:   n_state = prf_pkg::SL_D3;
            prf_pkg::SL_D3:   n_state = prf_pkg::SL_NUM;
            prf_pkg::SL_NUM:  n_state = prf_pkg::SL_NUMR;
            prf_pkg::SL_NUMR: n_state = prf_pkg::SL_ABS;
            prf_pkg::SL_ABS:  n_state = prf_pkg::SL_LOAD;
            prf_pkg::SL_LOAD: n_state = prf_pkg::SL_DIV;
            prf_pkg::SL_DIV:  if (last_step) n_state = prf_pkg::SL_DONE;
            prf_pkg::SL_DONE: n_state = prf_pkg::SL_IDLE;
            default:          n_state = prf_pkg::SL_IDLE;
        endcase
    end

    // Select shared multiplier operands: denominator chain, then 6*(L+1)*S
    always_comb begin
        len_p1 = B_W'(i_len) + B_W'(1);
        mul_a  = '0;
        mul_b  = '0;
        unique case (r_state)
            prf_pkg::SL_D1: begin
                mul_a = A_W'(i_len) + A_W'(1);
                mul_b = B_W'(i_len) - B_W'(1);
            end
            prf_pkg::SL_D2: begin
                mul_a = r_prod[A_W-1:0];
                mul_b = B_W'(i_len);
            end
            prf_pkg::SL_D3: begin
                mul_a = r_prod[A_W-1:0];
                mul_b = B_W'(FFT_LEN);
            end
            prf_pkg::SL_NUM: begin
                mul_a = A_W'(i_sum);
                mul_b = (len_p1 << 2) + (len_p1 << 1);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p     = mul_a * $signed({1'b0, mul_b});
    assign wsum_x    = NUM_W'(i_wsum);
    assign ge        = r_rem >= r_dsh;
    assign last_step = r_step == STEP_W'(prf_pkg::QUO_W - 1);

    // Advance the datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= prf_pkg::SL_IDLE;
        end else begin
            r_state <= n_state;
        end
        case (r_state) inside
            prf_pkg::SL_D1, prf_pkg::SL_D2, prf_pkg::SL_D3: begin
                r_prod <= mul_p[P_W-1:0];
            end
            prf_pkg::SL_NUM: begin
                r_den  <= r_prod[DEN_W-1:0];
                r_prod <= mul_p[P_W-1:0];
                r_w12  <= (wsum_x <<< 3) + (wsum_x <<< 2);
            end
            prf_pkg::SL_NUMR: begin
                r_num <= r_w12 - NUM_W'(r_prod);
            end
            prf_pkg::SL_ABS: begin
                r_neg <= r_num[NUM_W-1];
                r_mag <= r_num[NUM_W-1] ? NUM_W'(-r_num) : NUM_W'(r_num);
            end
            prf_pkg::SL_LOAD: begin
                // add half the divisor for round to nearest
                r_rem  <= DIV_W'({r_mag, {prf_pkg::FRAC_W{1'b0}}}) + DIV_W'(r_den >> 1);
                r_dsh  <= DIV_W'({r_den, {(prf_pkg::QUO_W-1){1'b0}}});
                r_quo  <= '0;
                r_step <= '0;
            end
            prf_pkg::SL_DIV: begin
                // one quotient bit per cycle, the first one flags overflow
                if (ge) begin
                    r_rem <= r_rem - r_dsh;
                end
                r_dsh  <= r_dsh >> 1;
                r_quo  <= {r_quo[prf_pkg::QUO_W-2:0], ge};
                r_step <= r_step + STEP_W'(1);
            end
            default: begin
            end
        endcase
    end

    // Apply sign and saturate
    always_comb begin
        quo_t  = r_quo[prf_pkg::FREQ_W-1:0];
        big    = r_quo[prf_pkg::QUO_W-1] | quo_t[prf_pkg::FREQ_W-1];
        o_done = r_state == prf_pkg::SL_DONE;
        if (r_neg) begin
            o_freq = big ? prf_pkg::SAT_NEG : (~quo_t + prf_pkg::FREQ_W'(1));
        end else begin
            o_freq = big ? prf_pkg::SAT_POS : quo_t;
        end
    end

endmodule

// ===== design/pilot_phase_regression_freq_core.sv =====
// Pilot phase regression frequency estimator, top level.
// Usage:
//   i_in carries one pair of pilot phases per word (signed Q15, 32768 = pi).
//   o_out carries one pair of frequency estimates (16 fractional bits,
//   saturated) after every len_regr input words; other words give nothing.
//   i_cfg_wr_en / i_cfg_wr_data write len_regr (clamped to 2..MAX_LEN on use);
//   write it only while the core is idle.
// Sequence:
//   A word that does not close a block passes the accept state and two
//   unwrap/accumulate steps per pilot through one shared unwrap unit.
//   For the closing word the shared slope unit then runs once per pilot:
//   start, multiplier and setup steps, a 33-step restoring divider and a
//   done state; after both runs the output register loads the pair.
// Reset:
//   Sums, count and unwrap history clear; len_regr returns to 16. The first
//   word after reset seeds the unwrap history.
// Stall:
//   The result waits in the output register while the next words are taken;
//   the core only holds when a new result is ready and the old one is unread.
// Depends on prf_pkg, prf_in_if, prf_out_if, prf_accum and prf_slope.
module pilot_phase_regression_freq_core #(
    parameter int FFT_LEN = prf_pkg::FFT_LEN_DEF,
    parameter int MAX_LEN = prf_pkg::MAX_LEN_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    prf_in_if.sink                            i_in,
    prf_out_if.source                         o_out,
    input  logic                              i_cfg_wr_en,
    input  logic [prf_pkg::LEN_REG_W-1:0]     i_cfg_wr_data
);

    localparam int LEN_W = $clog2(MAX_LEN+1);

    prf_pkg::t_top_state r_state, n_state;

    logic [prf_pkg::LEN_REG_W-1:0]      r_len_regr;
    logic [LEN_W-1:0]                   r_len;
    logic [LEN_W-1:0]                   n_len;
    logic [LEN_W-1:0]                   r_count;
    logic [LEN_W-1:0]                   n_weight;
    logic                               r_seeded;
    logic signed [prf_pkg::PH_W-1:0]    r_ph0;
    logic signed [prf_pkg::PH_W-1:0]    r_ph1;
    logic signed [prf_pkg::FREQ_W-1:0]  r_res0;
    logic signed [prf_pkg::FREQ_W-1:0]  r_res1;
    logic                               r_out_valid;
    logic signed [prf_pkg::FREQ_W-1:0]  r_freq0;
    logic signed [prf_pkg::FREQ_W-1:0]  r_freq1;

    logic                               in_fire;
    logic                               out_fire;
    logic                               can_push;
    logic                               blk_done;
    logic                               slp_start;
    logic                               slp_done;
    logic signed [prf_pkg::FREQ_W-1:0]  slp_freq;
    logic signed [prf_pkg::SUM_W-1:0]   acc_sum;
    logic signed [prf_pkg::SUM_W-1:0]   acc_wsum;
    prf_pkg::t_acc_ctl                  acc_ctl;

    assign in_fire  = i_in.valid & i_in.ready;
    assign out_fire = r_out_valid & o_out.ready;
    assign can_push = !r_out_valid | o_out.ready;
    assign n_weight = r_count + LEN_W'(1);
    assign blk_done = n_weight >= r_len;

    // Clamp the block length to its legal range
    always_comb begin
        if (r_len_regr < prf_pkg::LEN_REG_W'(2)) begin
            n_len = LEN_W'(2);
        end else if (int'(r_len_regr) > MAX_LEN) begin
            n_len = LEN_W'(MAX_LEN);
        end else begin
            n_len = LEN_W'(r_len_regr);
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            prf_pkg::T_IDLE:  if (in_fire) n_state = prf_pkg::T_UNW0;
            prf_pkg::T_UNW0:  n_state = prf_pkg::T_MAC0;
            prf_pkg::T_MAC0:  n_state = prf_pkg::T_UNW1;
            prf_pkg::T_UNW1:  n_state = prf_pkg::T_MAC1;
            prf_pkg::T_MAC1:  n_state = blk_done ? prf_pkg::T_GO0 : prf_pkg::T_IDLE;
            prf_pkg::T_GO0:   n_state = prf_pkg::T_WAIT0;
            prf_pkg::T_WAIT0: if (slp_done) n_state = prf_pkg::T_GO1;
            prf_pkg::T_GO1:   n_state = prf_pkg::T_WAIT1;
            prf_pkg::T_WAIT1: if (slp_done) n_state = prf_pkg::T_PUSH;
            prf_pkg::T_PUSH:  if (can_push) n_state = prf_pkg::T_IDLE;
            default:          n_state = prf_pkg::T_IDLE;
        endcase
    end

    // Drive unit controls
    always_comb begin
        i_in.ready    = 1'b0;
        slp_start     = 1'b0;
        acc_ctl       = '0;
        acc_ctl.seed  = !r_seeded;
        unique case (r_state)
            prf_pkg::T_IDLE:  i_in.ready = 1'b1;
            prf_pkg::T_UNW0:  acc_ctl.unw = 1'b1;
            prf_pkg::T_MAC0:  acc_ctl.mac = 1'b1;
            prf_pkg::T_UNW1: begin
                acc_ctl.unw = 1'b1;
                acc_ctl.sel = 1'b1;
            end
            prf_pkg::T_MAC1: begin
                acc_ctl.mac = 1'b1;
                acc_ctl.sel = 1'b1;
            end
            prf_pkg::T_GO0:   slp_start = 1'b1;
            prf_pkg::T_WAIT0: acc_ctl.sel = 1'b0;
            prf_pkg::T_GO1: begin
                slp_start   = 1'b1;
                acc_ctl.sel = 1'b1;
            end
            prf_pkg::T_WAIT1: acc_ctl.sel = 1'b1;
            prf_pkg::T_PUSH:  acc_ctl.clear = can_push;
            default:          i_in.ready = 1'b0;
        endcase
    end

    // Hold configuration, sequencer and block count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= prf_pkg::T_IDLE;
            r_len_regr <= prf_pkg::LEN_RESET;
            r_count    <= '0;
            r_seeded   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_wr_en) begin
                r_len_regr <= i_cfg_wr_data;
            end
            if (r_state == prf_pkg::T_UNW1) begin
                r_seeded <= 1'b1;
            end
            if (r_state == prf_pkg::T_MAC1) begin
                r_count <= blk_done ? '0 : n_weight;
            end
        end
    end

    // Capture the input word and the slope results
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_ph0 <= i_in.phase_pilot0;
            r_ph1 <= i_in.phase_pilot1;
            r_len <= n_len;
        end
        if (r_state == prf_pkg::T_WAIT0 && slp_done) begin
            r_res0 <= slp_freq;
        end
        if (r_state == prf_pkg::T_WAIT1 && slp_done) begin
            r_res1 <= slp_freq;
        end
    end

    // Output register: load on push, drop on handoff
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == prf_pkg::T_PUSH && can_push) begin
            r_out_valid <= 1'b1;
        end else if (out_fire) begin
            r_out_valid <= 1'b0;
        end
        if (r_state == prf_pkg::T_PUSH && can_push) begin
            r_freq0 <= r_res0;
            r_freq1 <= r_res1;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.freq_pilot0 = r_freq0;
    assign o_out.freq_pilot1 = r_freq1;

    prf_accum #(
        .MAX_LEN (MAX_LEN)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (acc_ctl),
        .i_weight (n_weight),
        .i_phase0 (r_ph0),
        .i_phase1 (r_ph1),
        .o_sum    (acc_sum),
        .o_wsum   (acc_wsum)
    );

    prf_slope #(
        .FFT_LEN (FFT_LEN),
        .MAX_LEN (MAX_LEN)
    ) u_slope (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (slp_start),
        .i_len   (r_len),
        .i_sum   (acc_sum),
        .i_wsum  (acc_wsum),
        .o_done  (slp_done),
        .o_freq  (slp_freq)
    );

endmodule

// ===== tb/prf_freq_checker.sv =====
// Scoreboard for the pilot phase regression core: watches both channels and the
// register port, predicts each frequency word and compares it field by field.
// Depends on prf_pkg, prf_in_if and prf_out_if.
module prf_freq_checker #(
    parameter int FFT_LEN = prf_pkg::FFT_LEN_DEF,
    parameter int MAX_LEN = prf_pkg::MAX_LEN_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    prf_in_if                             i_in_mon,
    prf_out_if                            i_out_mon,
    input  logic                          i_cfg_wr_en,
    input  logic [prf_pkg::LEN_REG_W-1:0] i_cfg_wr_data,
    output int                            o_fail_count,
    output int                            o_pending
);
    import prf_pkg::*;

    typedef struct packed {
        logic [FREQ_W-1:0] freq0;
        logic [FREQ_W-1:0] freq1;
    } freq_pair_t;

    // Shadow copy of the core's register and running state
    logic [LEN_REG_W-1:0] block_len;
    logic [PH_W-1:0]      last_phase [2];
    logic [OFF_W-1:0]     turn_offset [2];
    logic [SUM_W-1:0]     phase_sum [2];
    logic [SUM_W-1:0]     weighted_sum [2];
    logic [LEN_REG_W-1:0] words_in_block;
    logic                 seeded;

    freq_pair_t expected_freqs [$];
    int         fail_cnt = 0;

    // Least-squares slope per sample, rounded half away from zero, then saturated
    function automatic logic [FREQ_W-1:0] slope_freq(input logic [SUM_W-1:0] sum_raw,
                                                     input logic [SUM_W-1:0] wsum_raw,
                                                     input int span);
        longint     s;
        longint     w;
        longint     num;
        logic [63:0] den;
        logic [63:0] mag;
        logic [63:0] quo;
        logic [63:0] rem;
        logic [63:0] frac;
        logic [63:0] scaled;
        logic [63:0] negated;
        s      = longint'($signed(sum_raw));
        w      = longint'($signed(wsum_raw));
        num    = 12 * w - 6 * longint'(span + 1) * s;
        den    = 64'(span + 1) * 64'(span - 1) * 64'(span) * 64'(FFT_LEN);
        mag    = (num < 0) ? 64'(-num) : 64'(num);
        quo    = mag / den;
        rem    = mag % den;
        frac   = ((rem << FRAC_W) + den / 2) / den;
        scaled = (quo << FRAC_W) + frac;
        if (num < 0) begin
            negated = 64'd0 - scaled;
            return (scaled >= 64'h8000_0000) ? SAT_NEG : negated[FREQ_W-1:0];
        end
        return (scaled > 64'h7FFF_FFFF) ? SAT_POS : scaled[FREQ_W-1:0];
    endfunction

    // Unwrap both pilots, accumulate, and close the block when it is full
    task automatic take_word(input logic [PH_W-1:0] ph0, input logic [PH_W-1:0] ph1);
        int                   span;
        longint               step;
        longint               unwrapped;
        logic [63:0]          unw_bits;
        logic [63:0]          product;
        logic [PH_W-1:0]      raw [2];
        logic [LEN_REG_W-1:0] weight;
        freq_pair_t           result;
        span   = (block_len < 2) ? 2 : (int'(block_len) > MAX_LEN) ? MAX_LEN : int'(block_len);
        raw[0] = ph0;
        raw[1] = ph1;
        // First word after reset seeds the unwrap history
        if (!seeded) begin
            for (int p = 0; p < 2; p++) begin
                last_phase[p]  = raw[p];
                turn_offset[p] = '0;
            end
            seeded = 1'b1;
        end
        weight = words_in_block + 1'b1;
        for (int p = 0; p < 2; p++) begin
            step = longint'($signed(raw[p])) - longint'($signed(last_phase[p]));
            // Only a step strictly larger than half a turn counts as a wrap
            if (step > 32768) begin
                turn_offset[p] = turn_offset[p] - TURN;
            end else if (step < -32768) begin
                turn_offset[p] = turn_offset[p] + TURN;
            end
            last_phase[p]   = raw[p];
            unwrapped       = longint'($signed(turn_offset[p])) + longint'($signed(raw[p]));
            unw_bits        = unwrapped;
            product         = unw_bits * 64'(weight);
            phase_sum[p]    = phase_sum[p] + unw_bits[SUM_W-1:0];
            weighted_sum[p] = weighted_sum[p] + product[SUM_W-1:0];
        end
        words_in_block = weight;
        if (int'(weight) >= span) begin
            result.freq0 = slope_freq(phase_sum[0], weighted_sum[0], span);
            result.freq1 = slope_freq(phase_sum[1], weighted_sum[1], span);
            expected_freqs.push_back(result);
            for (int p = 0; p < 2; p++) begin
                phase_sum[p]    = '0;
                weighted_sum[p] = '0;
            end
            words_in_block = '0;
        end
    endtask

    task automatic compare_field(input string name, input logic [FREQ_W-1:0] want,
                                 input logic [FREQ_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, $signed(want), $signed(got));
            fail_cnt++;
        end
    endtask

    // Check outgoing words before predicting from the incoming one
    always @(posedge i_clk) begin : watch
        freq_pair_t want;
        if (!i_rst_n) begin
            block_len      = LEN_RESET;
            words_in_block = '0;
            seeded         = 1'b0;
            for (int p = 0; p < 2; p++) begin
                last_phase[p]   = '0;
                turn_offset[p]  = '0;
                phase_sum[p]    = '0;
                weighted_sum[p] = '0;
            end
            expected_freqs.delete();
        end else begin
            if (i_out_mon.valid && i_out_mon.ready) begin
                if (expected_freqs.size() == 0) begin
                    $error("frequency word with none expected: freq_pilot0 %0d freq_pilot1 %0d",
                           i_out_mon.freq_pilot0, i_out_mon.freq_pilot1);
                    fail_cnt++;
                end else begin
                    want = expected_freqs.pop_front();
                    compare_field("freq_pilot0", want.freq0, i_out_mon.freq_pilot0);
                    compare_field("freq_pilot1", want.freq1, i_out_mon.freq_pilot1);
                end
            end
            if (i_in_mon.valid && i_in_mon.ready) begin
                take_word(i_in_mon.phase_pilot0, i_in_mon.phase_pilot1);
            end
            if (i_cfg_wr_en) begin
                block_len = i_cfg_wr_data;
            end
        end
        o_pending    <= expected_freqs.size();
        o_fail_count <= fail_cnt;
    end

endmodule

// ===== tb/tb_pilot_phase_regression_freq_core.sv =====
// Testbench top for the pilot phase regression core: clock, reset, stimulus,
// receiver back-pressure and the verdict; prediction lives in prf_freq_checker.
// Depends on prf_pkg, prf_in_if, prf_out_if, prf_freq_checker and the core.
module tb_pilot_phase_regression_freq_core;
    import prf_pkg::*;

    localparam int SEG_WORDS   = 57;
    localparam int SEGS        = 8;
    localparam int SPIN_WORDS  = 64;
    localparam int SETTLE_CYC  = 16;
    localparam int LONG_HOLD   = 400;
    localparam int RUN_LIMIT   = 3000000;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 cfg_wr_en   = 1'b0;
    logic [LEN_REG_W-1:0] cfg_wr_data = '0;
    logic                 tx_valid    = 1'b0;
    logic [PH_W-1:0]      tx_p0       = '0;
    logic [PH_W-1:0]      tx_p1       = '0;
    logic                 rx_ready    = 1'b0;

    int tx_idle_pct   = 0;
    int rx_idle_pct   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int fail_count;
    int pending;

    logic [PH_W-1:0] last_sent0 = '0;
    logic [PH_W-1:0] last_sent1 = '0;
    logic [PH_W-1:0] rate0      = '0;
    logic [PH_W-1:0] rate1      = '0;

    // Directed phase pairs: extremes, exact half-turn steps and just-over wraps
    localparam logic [7:0][PH_W-1:0] DIR_P0 = {16'h0001, 16'h8000, 16'h0000, 16'h7F9D,
                                               16'hFF9C, 16'hFFFF, 16'h7FFF, 16'h8000};
    localparam logic [7:0][PH_W-1:0] DIR_P1 = {16'hFFFF, 16'h7FFF, 16'h0000, 16'h8063,
                                               16'h0064, 16'h0000, 16'h8000, 16'h7FFF};

    prf_in_if  in_ch ();
    prf_out_if out_ch ();

    assign in_ch.valid        = tx_valid;
    assign in_ch.phase_pilot0 = tx_p0;
    assign in_ch.phase_pilot1 = tx_p1;
    assign out_ch.ready       = rx_ready;

    pilot_phase_regression_freq_core #(
        .FFT_LEN(FFT_LEN_DEF),
        .MAX_LEN(MAX_LEN_DEF)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .o_out        (out_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data)
    );

    prf_freq_checker #(
        .FFT_LEN(FFT_LEN_DEF),
        .MAX_LEN(MAX_LEN_DEF)
    ) i_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_mon     (in_ch),
        .i_out_mon    (out_ch),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_wr_data(cfg_wr_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // Abort a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_served <= hold_requests;
            hold_left   <= LONG_HOLD;
            rx_ready    <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rx_ready  <= 1'b0;
        end else begin
            rx_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one word after a random gap and hold it until accepted
    task automatic offer(input logic [PH_W-1:0] p0, input logic [PH_W-1:0] p1);
        while ($urandom_range(99) < tx_idle_pct) begin
            tx_valid <= 1'b0;
            @(posedge i_clk);
        end
        tx_valid   <= 1'b1;
        tx_p0      <= p0;
        tx_p1      <= p1;
        last_sent0 = p0;
        last_sent1 = p1;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    // Drop valid, wait for every expected word, then let the core go idle
    task automatic settle();
        tx_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_len(input logic [LEN_REG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge i_clk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Mostly a drifting tone with noise, the rest random, half-turn or extreme steps
    task automatic random_word();
        int              kind;
        logic [PH_W-1:0] n0;
        logic [PH_W-1:0] n1;
        kind = $urandom_range(99);
        if (kind < 70) begin
            n0 = last_sent0 + rate0 + 16'($urandom_range(1023)) - 16'd512;
            n1 = last_sent1 + rate1 + 16'($urandom_range(1023)) - 16'd512;
        end else if (kind < 82) begin
            n0 = 16'($urandom);
            n1 = 16'($urandom);
        end else if (kind < 94) begin
            n0 = last_sent0 + 16'(32767 + $urandom_range(2));
            n1 = last_sent1 + 16'(32767 + $urandom_range(2));
        end else begin
            n0 = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
            n1 = $urandom_range(1) ? 16'h8000 : 16'h7FFF;
        end
        offer(n0, n1);
    endtask

    function automatic logic [LEN_REG_W-1:0] segment_len(input int seg);
        case (seg)
            0: return 7'd64;
            1: return 7'd2;
            2: return 7'd0;
            3: return 7'd127;
            4: return 7'd1;
            5: return 7'd65;
            default: return 7'($urandom_range(127));
        endcase
    endfunction

    initial begin
        logic [PH_W-1:0] spin_step;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words at the reset length: seed, wraps, exact half turns
        for (int i = 0; i < 20; i++) begin
            if (i < 8) begin
                offer(DIR_P0[i], DIR_P1[i]);
            end else begin
                offer(16'($urandom), 16'($urandom));
            end
        end
        // Lower the length mid-block, then go below the minimum
        settle();
        write_len(7'd3);
        offer(16'($urandom), 16'($urandom));
        settle();
        write_len(7'd1);
        repeat (2) offer(16'($urandom), 16'($urandom));

        // Random segments under three idling mixes
        for (int ph = 0; ph < 3; ph++) begin
            tx_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 60 : 0;
            rx_idle_pct = (ph == 0) ? 60 : (ph == 1) ? 21 : 0;
            for (int seg = 0; seg < SEGS; seg++) begin
                settle();
                write_len(segment_len(seg));
                rate0 = $urandom_range(1) ? 16'($urandom_range(4095)) - 16'd2048 : 16'($urandom);
                rate1 = $urandom_range(1) ? 16'($urandom_range(4095)) - 16'd2048 : 16'($urandom);
                // Stall the receiver for a long stretch on the shortest blocks
                if (ph == 2 && seg == 1) begin
                    hold_requests <= hold_requests + 1;
                end
                repeat (SEG_WORDS) random_word();
            end
        end

        // Spin both pilots near half a turn per word so the offsets grow fast
        settle();
        write_len(7'd64);
        for (int i = 0; i < SPIN_WORDS; i++) begin
            spin_step = 16'(32752 + $urandom_range(15));
            offer(last_sent0 + spin_step, last_sent1 - spin_step);
        end

        settle();
        if (fail_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
